### rtl/core/byte_ring_fifo_with_delimiter_take_top_assert.svh
// Assertion macros for the byte ring FIFO top level.
`ifndef BYTE_RING_FIFO_WITH_DELIMITER_TAKE_TOP_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_DELIMITER_TAKE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define BRFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BRFD_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define BRFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define BRFD_ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif

`endif

### rtl/core/brfd_pkg.sv
// Shared types, constants and helper functions of the byte ring FIFO.
package brfd_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int MODE_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int RCNT_W  = 7;
  localparam int FREE_W  = 7;
  localparam int USED_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE  = 3'd0,
    MODE_READ   = 3'd1,
    MODE_TAKE   = 3'd2,
    MODE_DRAIN  = 3'd3,
    MODE_CLEAR  = 3'd4,
    MODE_STATUS = 3'd5
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELIM_USED = 3'd0,
    CFG_DELIM_A    = 3'd1,
    CFG_DELIM_B    = 3'd2,
    CFG_DELIM_C    = 3'd3,
    CFG_DELIM_D    = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] in_byte;
    logic [RCNT_W-1:0] read_count;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              accepted;
    logic              last;
    logic [FREE_W-1:0] free_count;
    logic              is_empty;
    logic              is_full;
  } out_item_t;

  // Ring pointer increment that wraps at DEPTH, also for depths that are not a power of two.
  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  // True when the byte matches one of the delimiters in use; counts above four act as four.
  function automatic logic delim_hit(logic [BYTE_W-1:0] b, logic [USED_W-1:0] used,
                                     logic [BYTE_W-1:0] d0, logic [BYTE_W-1:0] d1,
                                     logic [BYTE_W-1:0] d2, logic [BYTE_W-1:0] d3);
    return ((used >= USED_W'(1)) && (b == d0)) ||
           ((used >= USED_W'(2)) && (b == d1)) ||
           ((used >= USED_W'(3)) && (b == d2)) ||
           ((used >= USED_W'(4)) && (b == d3));
  endfunction

endpackage

### rtl/core/brfd_ram.sv
// Generic single write port, single read port RAM with registered read data.
module brfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/byte_ring_fifo_with_delimiter_take_top.sv
// Top level of the byte ring FIFO with delimiter take.
`include "byte_ring_fifo_with_delimiter_take_top_assert.svh"

// A ring of DEPTH bytes in a synchronous RAM, driven by a command port. A command is
// taken at a rising edge where start_i is high and busy_o is low. Write, clear, status
// and any read command that finds nothing to take give exactly one result. A read
// command that takes n bytes (read count, take to delimiter, drain) keeps busy_o high
// until its last byte is out and gives n results; from the second byte on one byte
// streams out per cycle, paced by the single read port of the byte store and its
// registered read data. Each result shows on res_o for exactly one cycle with
// res_valid_o high, one cycle after the edge that produced it, and there is no
// back-pressure: the receiver must take every transfer as it comes. Every result
// carries the free space and the empty and full flags as they stand after that
// result. Configuration writes on cfg_we_i are taken at once and are meant for
// times when the block is idle. The byte store has no reset; only written entries
// are ever read.
module byte_ring_fifo_with_delimiter_take_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  brfd_pkg::in_item_t                    item_i,
  input  logic                                  cfg_we_i,
  input  logic [brfd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [brfd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  output logic                                  res_valid_o,
  output brfd_pkg::out_item_t                   res_o
);
  import brfd_pkg::*;

  // Configuration registers.
  logic [USED_W-1:0] delim_used_q;
  logic [BYTE_W-1:0] delim_a_q, delim_b_q, delim_c_q, delim_d_q;

  // Ring control state. The fill count stands in for the empty flag: it tells a
  // full ring from an empty one when the pointers meet.
  state_e           state_q, state_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] held_q, held_d;

  // Burst bookkeeping. The issue side runs one entry ahead of the emit side because
  // read data arrives in the cycle after its address.
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] iss_left_q, iss_left_d;
  logic [PTR_W-1:0] iss_ptr_q, iss_ptr_d;
  logic             pend_q, pend_d;
  logic             take_q, take_d;

  // Result register.
  out_item_t res_q, res_d;
  logic      res_vld_q, res_vld_d;

  // RAM port signals.
  logic              ram_we;
  logic              ram_re;
  logic [BYTE_W-1:0] ram_rdata;

  logic              last_byte;
  logic [CNT_W-1:0]  take_n;
  logic [CNT_W-1:0]  held_dec;

  brfd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (item_i.in_byte),
    .re_i    (ram_re),
    .raddr_i (iss_ptr_q),
    .rdata_o (ram_rdata)
  );

  // Builds an empty result whose status fields describe a fill level of h bytes.
  function automatic out_item_t status_res(logic [CNT_W-1:0] h);
    out_item_t r;
    r            = '0;
    r.last       = 1'b1;
    r.free_count = FREE_W'(DEPTH) - FREE_W'(h);
    r.is_empty   = (h == '0);
    r.is_full    = (h == CNT_W'(DEPTH));
    return r;
  endfunction

  // Configuration write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_used_q <= USED_W'(1);
      delim_a_q    <= BYTE_W'(10);
      delim_b_q    <= '0;
      delim_c_q    <= '0;
      delim_d_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_DELIM_USED: delim_used_q <= cfg_wdata_i[USED_W-1:0];
        CFG_DELIM_A:    delim_a_q    <= cfg_wdata_i;
        CFG_DELIM_B:    delim_b_q    <= cfg_wdata_i;
        CFG_DELIM_C:    delim_c_q    <= cfg_wdata_i;
        CFG_DELIM_D:    delim_d_q    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      held_q     <= '0;
      rem_q      <= '0;
      iss_left_q <= '0;
      iss_ptr_q  <= '0;
      pend_q     <= 1'b0;
      take_q     <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_ptr_q   <= rd_ptr_d;
      wr_ptr_q   <= wr_ptr_d;
      held_q     <= held_d;
      rem_q      <= rem_d;
      iss_left_q <= iss_left_d;
      iss_ptr_q  <= iss_ptr_d;
      pend_q     <= pend_d;
      take_q     <= take_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // The bytes a read count command takes: the smaller of the count and the fill level.
  assign take_n   = (item_i.read_count < RCNT_W'(held_q)) ? item_i.read_count[CNT_W-1:0]
                                                         : held_q;
  assign held_dec = held_q - CNT_W'(1);

  // The byte coming back from the store closes the burst when it is the last one
  // counted or, in take mode, when it is a delimiter.
  assign last_byte = (rem_q == CNT_W'(1)) ||
                     (take_q && delim_hit(ram_rdata, delim_used_q, delim_a_q, delim_b_q,
                                          delim_c_q, delim_d_q));

  always_comb begin
    state_d    = state_q;
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    held_d     = held_q;
    rem_d      = rem_q;
    iss_left_d = iss_left_q;
    iss_ptr_d  = iss_ptr_q;
    pend_d     = 1'b0;
    take_d     = take_q;
    res_d      = status_res(held_q);
    res_vld_d  = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          res_vld_d = 1'b1;
          unique case (mode_e'(item_i.mode))
            MODE_WRITE: begin
              if (held_q != CNT_W'(DEPTH)) begin
                ram_we         = 1'b1;
                wr_ptr_d       = ptr_inc(wr_ptr_q);
                held_d         = held_q + CNT_W'(1);
                res_d          = status_res(held_q + CNT_W'(1));
                res_d.accepted = 1'b1;
              end
            end
            MODE_READ, MODE_TAKE, MODE_DRAIN: begin
              if (mode_e'(item_i.mode) == MODE_READ) begin
                rem_d = take_n;
              end else begin
                rem_d = held_q;
              end
              iss_left_d = rem_d;
              iss_ptr_d  = rd_ptr_q;
              take_d     = (mode_e'(item_i.mode) == MODE_TAKE);
              if (rem_d != '0) begin
                // Bytes come out of the burst; no result for the command itself.
                res_vld_d = 1'b0;
                state_d   = ST_BURST;
              end
            end
            MODE_CLEAR: begin
              rd_ptr_d = '0;
              wr_ptr_d = '0;
              held_d   = '0;
              res_d    = status_res('0);
            end
            default: begin
            end
          endcase
        end
      end
      ST_BURST: begin
        if (pend_q) begin
          res_vld_d        = 1'b1;
          res_d            = status_res(held_dec);
          res_d.out_byte   = ram_rdata;
          res_d.byte_valid = 1'b1;
          res_d.last       = last_byte;
          rd_ptr_d         = ptr_inc(rd_ptr_q);
          held_d           = held_dec;
          rem_d            = rem_q - CNT_W'(1);
        end
        if (pend_q && last_byte) begin
          state_d = ST_IDLE;
        end else if (iss_left_q != '0) begin
          ram_re     = 1'b1;
          iss_ptr_d  = ptr_inc(iss_ptr_q);
          iss_left_d = iss_left_q - CNT_W'(1);
          pend_d     = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q == ST_BURST);
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  // The fill level never goes past the ring size.
  `BRFD_ASSERT(a_held_bound, clk_i, rst_ni, held_q <= CNT_W'(DEPTH), "fill level above depth")
  // Read data is only consumed in the cycle after a read was issued.
  `BRFD_ASSERT(a_pend_follows_read, clk_i, rst_ni, pend_q |-> $past(ram_re), "stale read data")
  // A transfer that empties the ring during a burst must close that burst.
  `BRFD_ASSERT_NEVER(a_empty_closes, clk_i, rst_ni,
    res_valid_o && res_o.byte_valid && res_o.is_empty && !res_o.last,
    "ring emptied without last")
  // No store write happens while a burst is reading the ring.
  `BRFD_ASSERT_NEVER(a_no_write_in_burst, clk_i, rst_ni, busy_o && ram_we, "write during burst")

endmodule

### verif/testbench.sv
// Self-checking testbench of the byte ring FIFO with delimiter take.
module testbench;
  import brfd_pkg::*;

  // The two mode codes that the package leaves unnamed; the block treats both as status.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned GAP_MAX = 12;

  typedef struct {
    in_item_t    item;
    int unsigned gap;
    bit          hold;
  } cmd_entry_t;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  logic                  busy_o;
  in_item_t              item_i      = '0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  res_valid_o;
  out_item_t             res_o;

  byte_ring_fifo_with_delimiter_take_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Shadow copy of the ring, its pointers and the delimiter registers.
  logic [BYTE_W-1:0] ring_mem [DEPTH];
  logic [PTR_W-1:0]  rd_ptr     = '0;
  logic [PTR_W-1:0]  wr_ptr     = '0;
  bit                ring_empty = 1'b1;
  logic [USED_W-1:0] delim_count = 3'd1;
  logic [BYTE_W-1:0] delim_val [4] = '{8'd10, 8'd0, 8'd0, 8'd0};

  out_item_t   fifo_expect [$];
  cmd_entry_t  cmd_backlog [$];
  int unsigned queued_total   = 0;
  int unsigned accepted_total = 0;
  int unsigned result_index   = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;
  int unsigned gap_ceiling    = GAP_MAX;

  // Driver-side staging of the next command.
  cmd_entry_t  staged_cmd;
  bit          staged    = 1'b0;
  bit          drv_launch;
  int unsigned idle_left = 0;

  function automatic int unsigned fill_level();
    if (rd_ptr == wr_ptr) begin
      return ring_empty ? DEPTH - DEPTH : DEPTH;
    end
    return (int'(wr_ptr) + DEPTH - int'(rd_ptr)) % DEPTH;
  endfunction

  function automatic bit byte_is_delim(logic [BYTE_W-1:0] b);
    int unsigned n;
    n = (delim_count > 3'd4) ? 4 : int'(delim_count);
    for (int i = 0; i < n; i++) begin
      if (b == delim_val[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Queues one expected result; free space and flags reflect the ring after this result.
  task automatic push_expect(logic [BYTE_W-1:0] b, bit valid, bit acc, bit last);
    out_item_t   r;
    int unsigned lvl;
    lvl          = fill_level();
    r.out_byte   = b;
    r.byte_valid = valid;
    r.accepted   = acc;
    r.last       = last;
    r.free_count = FREE_W'(DEPTH - lvl);
    r.is_empty   = (lvl == 0);
    r.is_full    = (lvl == DEPTH);
    fifo_expect.push_back(r);
  endtask

  // Pops n bytes from the shadow ring, one result each; nothing to take gives one empty result.
  task automatic emit_bytes(int unsigned n);
    logic [BYTE_W-1:0] b;
    if (n == 0) begin
      push_expect('0, 1'b0, 1'b0, 1'b1);
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        b      = ring_mem[rd_ptr];
        rd_ptr = PTR_W'((int'(rd_ptr) + 1) % DEPTH);
        if (rd_ptr == wr_ptr) ring_empty = 1'b1;
        push_expect(b, 1'b1, 1'b0, i + 1 == n);
      end
    end
  endtask

  task automatic predict_fifo(in_item_t it);
    int unsigned lvl;
    int unsigned n;
    lvl = fill_level();
    case (it.mode)
      MODE_WRITE: begin
        if (lvl == DEPTH) begin
          push_expect('0, 1'b0, 1'b0, 1'b1);
        end else begin
          ring_mem[wr_ptr] = it.in_byte;
          wr_ptr     = PTR_W'((int'(wr_ptr) + 1) % DEPTH);
          ring_empty = 1'b0;
          push_expect('0, 1'b0, 1'b1, 1'b1);
        end
      end
      MODE_READ: begin
        n = (int'(it.read_count) < lvl) ? int'(it.read_count) : lvl;
        emit_bytes(n);
      end
      MODE_TAKE: begin
        // The scan covers every held byte, all DEPTH of them when the ring is full.
        n = lvl;
        for (int unsigned i = 0; i < lvl; i++) begin
          if (byte_is_delim(ring_mem[(int'(rd_ptr) + i) % DEPTH])) begin
            n = i + 1;
            break;
          end
        end
        emit_bytes(n);
      end
      MODE_DRAIN: emit_bytes(lvl);
      MODE_CLEAR: begin
        rd_ptr     = '0;
        wr_ptr     = '0;
        ring_empty = 1'b1;
        push_expect('0, 1'b0, 1'b0, 1'b1);
      end
      default: push_expect('0, 1'b0, 1'b0, 1'b1);
    endcase
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(string fname, int unsigned got, int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d field %s got %0d expected %0d",
                                result_index, fname, got, want));
    end
  endtask

  // Driver: a command is a transfer at an edge with start high and busy low. The start
  // and item signals change only when no command is waiting to be taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        predict_fifo(item_i);
        accepted_total++;
      end
      if (!start_i || !busy_o) begin
        drv_launch = 1'b0;
        if (!staged && cmd_backlog.size() != 0) begin
          staged_cmd = cmd_backlog.pop_front();
          staged     = 1'b1;
          idle_left  = staged_cmd.gap;
        end
        if (staged) begin
          if (idle_left != 0) begin
            idle_left--;
          end else if (!staged_cmd.hold || (fifo_expect.size() == 0 && !busy_o)) begin
            drv_launch = 1'b1;
            item_i    <= staged_cmd.item;
            staged     = 1'b0;
          end
        end
        start_i <= drv_launch;
      end
    end
  end

  // Monitor: every strobed result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if ($isunknown(res_valid_o)) begin
        report_mismatch("result strobe is unknown");
      end else if (res_valid_o) begin
        if ($isunknown(res_o)) begin
          report_mismatch($sformatf("result %0d carries unknown bits", result_index));
        end
        if (fifo_expect.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    result_index));
        end else begin
          want = fifo_expect.pop_front();
          check_field("out_byte",   int'(res_o.out_byte),   int'(want.out_byte));
          check_field("byte_valid", int'(res_o.byte_valid), int'(want.byte_valid));
          check_field("accepted",   int'(res_o.accepted),   int'(want.accepted));
          check_field("last",       int'(res_o.last),       int'(want.last));
          check_field("free_count", int'(res_o.free_count), int'(want.free_count));
          check_field("is_empty",   int'(res_o.is_empty),   int'(want.is_empty));
          check_field("is_full",    int'(res_o.is_full),    int'(want.is_full));
        end
        result_index++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic queue_cmd(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] data,
                           logic [RCNT_W-1:0] count, bit hold);
    cmd_entry_t e;
    e.item.mode       = mode;
    e.item.in_byte    = data;
    e.item.read_count = count;
    e.gap             = $urandom_range(0, gap_ceiling);
    e.hold            = hold;
    cmd_backlog.push_back(e);
    queued_total++;
  endtask

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(0, 255));
    while (byte_is_delim(b)) b = BYTE_W'($urandom_range(0, 255));
    return b;
  endfunction

  // Waits until every command has been taken, every result has come and the block is idle.
  task automatic wait_drained();
    while (accepted_total != queued_total || fifo_expect.size() != 0 || busy_o) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_DELIM_USED: delim_count  = value[USED_W-1:0];
      CFG_DELIM_A:    delim_val[0] = value;
      CFG_DELIM_B:    delim_val[1] = value;
      CFG_DELIM_C:    delim_val[2] = value;
      CFG_DELIM_D:    delim_val[3] = value;
      default: ;
    endcase
  endtask

  task automatic set_delims(logic [USED_W-1:0] used, logic [BYTE_W-1:0] a,
                            logic [BYTE_W-1:0] b, logic [BYTE_W-1:0] c,
                            logic [BYTE_W-1:0] d);
    wait_drained();
    write_reg(CFG_DELIM_USED, CFG_DATA_W'(used));
    write_reg(CFG_DELIM_A, a);
    write_reg(CFG_DELIM_B, b);
    write_reg(CFG_DELIM_C, c);
    write_reg(CFG_DELIM_D, d);
  endtask

  // Fills the ring to the top, tries one refused write, then takes with a full ring.
  // The prelude moves the pointers off zero so that the scan wraps around.
  task automatic queue_fill(bit wrap_first, bit delim_last);
    logic [BYTE_W-1:0] b;
    gap_ceiling = ($urandom_range(0, 1) != 0) ? GAP_MAX : 0;
    if (wrap_first) begin
      queue_cmd(MODE_DRAIN, '0, '0, 1'b0);
      for (int i = 0; i < 3; i++) queue_cmd(MODE_WRITE, plain_byte(), '0, 1'b0);
      queue_cmd(MODE_READ, '0, RCNT_W'(3), 1'b0);
    end
    for (int i = 0; i < DEPTH; i++) begin
      b = (delim_last && i == DEPTH - 1) ? delim_val[$urandom_range(0, 3)] : plain_byte();
      queue_cmd(MODE_WRITE, b, RCNT_W'($urandom_range(0, 127)), 1'b0);
    end
    queue_cmd(MODE_WRITE, BYTE_W'($urandom_range(0, 255)), '0, 1'b0);
    queue_cmd(MODE_STATUS, '0, '0, 1'b0);
    queue_cmd(MODE_TAKE, '0, '0, 1'b0);
    queue_cmd(MODE_READ, '0, RCNT_W'(4), 1'b0);
  endtask

  // One random sequence; most are writes followed by a read-mode command so that the
  // scan and the counts see real content, the rest is noise.
  task automatic queue_burst();
    int unsigned       kind;
    int unsigned       k;
    logic [BYTE_W-1:0] b;
    logic [RCNT_W-1:0] cnt;
    kind        = $urandom_range(0, 9);
    gap_ceiling = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
    if (kind <= 5) begin
      k = $urandom_range(1, 8);
      for (int unsigned i = 0; i < k; i++) begin
        b = ($urandom_range(0, 2) == 0) ? delim_val[$urandom_range(0, 3)]
                                        : BYTE_W'($urandom_range(0, 255));
        queue_cmd(MODE_WRITE, b, RCNT_W'($urandom_range(0, 127)), 1'b0);
      end
      case ($urandom_range(0, 3))
        0, 1: queue_cmd(MODE_TAKE, BYTE_W'($urandom_range(0, 255)),
                        RCNT_W'($urandom_range(0, 127)), 1'b0);
        2: begin
          cnt = ($urandom_range(0, 3) == 0) ? RCNT_W'($urandom_range(0, 127))
                                            : RCNT_W'($urandom_range(1, k + 2));
          queue_cmd(MODE_READ, BYTE_W'($urandom_range(0, 255)), cnt,
                    $urandom_range(0, 19) == 0);
        end
        default: queue_cmd(MODE_DRAIN, BYTE_W'($urandom_range(0, 255)),
                           RCNT_W'($urandom_range(0, 127)), 1'b0);
      endcase
    end else if (kind <= 7) begin
      queue_cmd(MODE_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)),
                RCNT_W'($urandom_range(0, 127)), 1'b0);
    end else if (kind == 8) begin
      queue_cmd(($urandom_range(0, 1) != 0) ? MODE_CLEAR : MODE_STATUS,
                BYTE_W'($urandom_range(0, 255)), RCNT_W'($urandom_range(0, 127)), 1'b0);
    end else begin
      k = $urandom_range(1, 4);
      for (int unsigned i = 0; i < k; i++) begin
        queue_cmd(MODE_WRITE, BYTE_W'($urandom_range(0, 255)),
                  RCNT_W'($urandom_range(0, 127)), 1'b0);
      end
    end
  endtask

  // The first command of each random phase waits until the ring has gone quiet.
  task automatic run_random(int unsigned n);
    int unsigned first;
    first = queued_total;
    gap_ceiling = GAP_MAX;
    queue_cmd(MODE_STATUS, BYTE_W'($urandom_range(0, 255)),
              RCNT_W'($urandom_range(0, 127)), 1'b1);
    while (queued_total - first < n) queue_burst();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the delimiter registers at their reset values: empty reads in
    // every read mode, the spare modes, a take that stops on a delimiter, counts of zero
    // and above the held bytes, a clear with content, and a take that finds no delimiter.
    gap_ceiling = 2;
    queue_cmd(MODE_STATUS, '0, '0, 1'b0);
    queue_cmd(MODE_READ, '0, RCNT_W'(5), 1'b0);
    queue_cmd(MODE_TAKE, '0, '0, 1'b0);
    queue_cmd(MODE_DRAIN, '0, '0, 1'b0);
    queue_cmd(MODE_SPARE_LO, 8'hFF, 7'h7F, 1'b0);
    queue_cmd(MODE_SPARE_HI, 8'hFF, 7'h7F, 1'b0);
    queue_cmd(MODE_WRITE, 8'h00, '0, 1'b0);
    queue_cmd(MODE_WRITE, 8'hFF, 7'h7F, 1'b0);
    queue_cmd(MODE_WRITE, 8'h0A, '0, 1'b0);
    queue_cmd(MODE_WRITE, 8'h55, '0, 1'b0);
    queue_cmd(MODE_WRITE, 8'hAA, '0, 1'b0);
    queue_cmd(MODE_TAKE, '0, '0, 1'b0);
    queue_cmd(MODE_READ, '0, '0, 1'b0);
    queue_cmd(MODE_READ, '0, RCNT_W'(1), 1'b0);
    queue_cmd(MODE_READ, '0, 7'h7F, 1'b0);
    queue_cmd(MODE_WRITE, 8'h0A, '0, 1'b0);
    queue_cmd(MODE_WRITE, 8'h3C, '0, 1'b0);
    queue_cmd(MODE_CLEAR, '0, '0, 1'b1);
    queue_cmd(MODE_STATUS, '0, '0, 1'b0);
    queue_cmd(MODE_WRITE, 8'h81, '0, 1'b0);
    queue_cmd(MODE_DRAIN, '0, '0, 1'b0);
    queue_cmd(MODE_WRITE, 8'h7E, '0, 1'b0);
    queue_cmd(MODE_WRITE, 8'h01, '0, 1'b0);
    queue_cmd(MODE_TAKE, '0, '0, 1'b0);

    // No delimiter in use: a take on a full, wrapped ring returns all of it.
    set_delims(3'd0, 8'hFF, 8'h00, 8'h80, 8'h7F);
    queue_fill(1'b1, 1'b0);
    run_random(3);

    // All four delimiters, a zero among them; the only one sits in the last full slot.
    set_delims(3'd4, 8'h00, 8'hFF, 8'h0A, 8'h55);
    queue_fill(1'b0, 1'b1);
    run_random(3);

    // A count above four acts as four.
    set_delims(3'd7, 8'h01, 8'h02, 8'h03, 8'h04);
    run_random(5);

    // Two delimiters, the second of them a zero byte.
    set_delims(3'd2, 8'h41, 8'h00, 8'hFE, 8'h80);
    run_random(5);

    wait_drained();
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
